// ===== hw/rtl/srs_pkg.sv =====
// Shared types and constants for the retransmit select pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package srs_pkg;

    // Sequence numbers wrap modulo 2^24.
    localparam int SN_W = 24;
    typedef logic [SN_W-1:0] sn_t;

    // Selective-ack bitmap port width and the part of it that is searched.
    localparam int BMP_W    = 64;
    localparam int WIN_BITS = 64;
    localparam int SHIFT_W  = $clog2(WIN_BITS);
    localparam int IDX_W    = $clog2(BMP_W);
    localparam logic [BMP_W-1:0] WIN_MASK = {BMP_W{1'b1}} >> (BMP_W - WIN_BITS);

    // Reset value of the in-flight limit register.
    localparam sn_t MAX_IN_FLIGHT_RST = sn_t'(64);

    // Per-record state that travels down the pipeline.
    typedef struct packed {
        logic send_allowed;
        sn_t  send_sn;
        sn_t  next_sn;
        sn_t  retransmit_sn;
        sn_t  recover_sn;
        logic in_recovery;
        logic search;
        sn_t  start_sn;
    } rec_t;

    // Window alignment for the hole search.
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic               empty;
    } win_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srs_decide.sv =====
// First pipeline stage: send decision, recovery update and search setup.
// Depends on srs_pkg.
`default_nettype none

module srs_decide
    import srs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             do_retransmit,
    input  wire sn_t              retransmit_sn,
    input  wire sn_t              last_acked_sn,
    input  wire logic             in_recovery,
    input  wire sn_t              recover_sn,
    input  wire sn_t              next_sn,
    input  wire logic             find_hole,
    input  wire logic [BMP_W-1:0] sel_ack_bits,
    input  wire sn_t              max_in_flight,
    output logic                  out_valid,
    output rec_t                  rec,
    output logic [BMP_W-1:0]      bitmap,
    output win_ctl_t              win_ctl
);

    logic             valid_reg;
    rec_t             rec_reg;
    rec_t             rec_next;
    logic [BMP_W-1:0] bitmap_reg;
    win_ctl_t         win_ctl_reg;
    win_ctl_t         win_ctl_next;

    logic ahead;
    logic take_retx;
    logic room;
    sn_t  retx_gap;
    sn_t  in_flight;

    // Sequence compares and the retransmit/new-send choice.
    always_comb
    begin
        ahead     = retransmit_sn >= last_acked_sn;
        retx_gap  = retransmit_sn - last_acked_sn;
        in_flight = next_sn - last_acked_sn;
        take_retx = do_retransmit & ahead;
        room      = in_flight < max_in_flight;

        rec_next.send_allowed  = take_retx | room;
        rec_next.send_sn       = take_retx ? retransmit_sn : (room ? next_sn : '0);
        rec_next.next_sn       = (!take_retx && room) ? next_sn + sn_t'(1) : next_sn;
        rec_next.retransmit_sn = retransmit_sn;
        rec_next.recover_sn    = take_retx ? next_sn - sn_t'(1) : recover_sn;
        rec_next.in_recovery   = in_recovery |
                                 (take_retx & (retransmit_sn == last_acked_sn));
        rec_next.search        = take_retx | (!do_retransmit & find_hole);
        rec_next.start_sn      = ahead ? retransmit_sn + sn_t'(1) : last_acked_sn;

        // The search starts just past retransmit_sn when it is in the window.
        win_ctl_next.empty = ahead & (retx_gap >= sn_t'(WIN_BITS - 1));
        win_ctl_next.shift = ahead ? retx_gap[SHIFT_W-1:0] + SHIFT_W'(1) : '0;
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rec_reg     <= rec_next;
            bitmap_reg  <= sel_ack_bits & WIN_MASK;
            win_ctl_reg <= win_ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign rec       = rec_reg;
    assign bitmap    = bitmap_reg;
    assign win_ctl   = win_ctl_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_window.sv =====
// Second pipeline stage: aligns the selective-ack window to the search start.
// Depends on srs_pkg.
`default_nettype none

module srs_window
    import srs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire rec_t             in_rec,
    input  wire logic [BMP_W-1:0] bitmap,
    input  wire win_ctl_t         win_ctl,
    output logic                  out_valid,
    output rec_t                  rec,
    output logic [BMP_W-1:0]      window
);

    logic             valid_reg;
    rec_t             rec_reg;
    logic [BMP_W-1:0] window_reg;
    logic [BMP_W-1:0] window_next;

    // Barrel shift; a start beyond the window leaves nothing to search.
    always_comb
    begin
        window_next = win_ctl.empty ? '0 : (bitmap >> win_ctl.shift);
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rec_reg    <= in_rec;
            window_reg <= window_next;
        end
    end

    assign out_valid = valid_reg;
    assign rec       = rec_reg;
    assign window    = window_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_hole.sv =====
// Third pipeline stage: trailing-ones count and hole detection on the window.
// Depends on srs_pkg.
`default_nettype none

module srs_hole
    import srs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire rec_t             in_rec,
    input  wire logic [BMP_W-1:0] window,
    output logic                  out_valid,
    output rec_t                  rec,
    output logic [IDX_W-1:0]      ones,
    output logic                  hole
);

    logic             valid_reg;
    rec_t             rec_reg;
    logic [IDX_W-1:0] ones_reg;
    logic [IDX_W-1:0] ones_next;
    logic             hole_reg;
    logic             hole_next;

    logic [BMP_W-1:0] zeros;
    logic [BMP_W-1:0] first_zero;
    logic [BMP_W-1:0] low_mask;

    // The first zero of the window marks the hole; a set bit above it is required.
    always_comb
    begin
        zeros      = ~window;
        first_zero = zeros & (~zeros + BMP_W'(1));
        low_mask   = zeros ^ (zeros - BMP_W'(1));
        hole_next  = |(window & ~low_mask);
        ones_next  = '0;
        for (int i = 0; i < BMP_W; i++)
        begin
            if (first_zero[i])
            begin
                ones_next = ones_next | IDX_W'(i);
            end
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rec_reg  <= in_rec;
            ones_reg <= ones_next;
            hole_reg <= hole_next;
        end
    end

    assign out_valid = valid_reg;
    assign rec       = rec_reg;
    assign ones      = ones_reg;
    assign hole      = hole_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sack_retransmit_select_unit.sv =====
// Top level of the retransmit select pipeline: config register and output stage.
// Depends on srs_pkg, srs_decide, srs_window and srs_hole.
//
//   Channel   Handshake             Contents
//   -------   -------------------   -----------------------------------------
//   command   start / busy          one sender record word
//   result    done (strobe)         one decision word, shown for one cycle
//   config    cfg_valid/cfg_ready   max_in_flight (24 bit)
//
// A record is taken in every cycle; busy stays low. Each result passes through
// the decide, window shift, hole search and output registers in that order.
// The receiver cannot stall, so results leave in order, one per accepted
// record. Reset clears the valid bits and sets max_in_flight to 64;
// cfg_ready is always high.
`default_nettype none

module sack_retransmit_select_unit
    import srs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // command channel
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             do_retransmit,
    input  wire sn_t              retransmit_sn,
    input  wire sn_t              last_acked_sn,
    input  wire logic             in_recovery,
    input  wire sn_t              recover_sn,
    input  wire sn_t              next_sn,
    input  wire logic             find_hole,
    input  wire logic [BMP_W-1:0] sel_ack_bits,
    // result channel
    output logic                  done,
    output logic                  send_allowed,
    output sn_t                   send_sn,
    output sn_t                   next_sn_out,
    output sn_t                   retransmit_sn_out,
    output logic                  do_retransmit_out,
    output sn_t                   recover_sn_out,
    output logic                  in_recovery_out,
    // configuration channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire sn_t              cfg_data
);

    sn_t              max_in_flight_reg;
    logic             accept;

    logic             s1_valid;
    rec_t             s1_rec;
    logic [BMP_W-1:0] s1_bitmap;
    win_ctl_t         s1_win_ctl;

    logic             s2_valid;
    rec_t             s2_rec;
    logic [BMP_W-1:0] s2_window;

    logic             s3_valid;
    rec_t             s3_rec;
    logic [IDX_W-1:0] s3_ones;
    logic             s3_hole;

    logic             done_reg;
    rec_t             out_rec_reg;
    logic             found_reg;
    logic             found_next;
    sn_t              retx_sn_reg;
    sn_t              retx_sn_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // In-flight limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_in_flight_reg <= MAX_IN_FLIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_in_flight_reg <= cfg_data;
        end
    end

    srs_decide u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .do_retransmit (do_retransmit),
        .retransmit_sn (retransmit_sn),
        .last_acked_sn (last_acked_sn),
        .in_recovery   (in_recovery),
        .recover_sn    (recover_sn),
        .next_sn       (next_sn),
        .find_hole     (find_hole),
        .sel_ack_bits  (sel_ack_bits),
        .max_in_flight (max_in_flight_reg),
        .out_valid     (s1_valid),
        .rec           (s1_rec),
        .bitmap        (s1_bitmap),
        .win_ctl       (s1_win_ctl)
    );

    srs_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_rec    (s1_rec),
        .bitmap    (s1_bitmap),
        .win_ctl   (s1_win_ctl),
        .out_valid (s2_valid),
        .rec       (s2_rec),
        .window    (s2_window)
    );

    srs_hole u_hole (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_rec    (s2_rec),
        .window    (s2_window),
        .out_valid (s3_valid),
        .rec       (s3_rec),
        .ones      (s3_ones),
        .hole      (s3_hole)
    );

    // A found hole replaces the retransmit sequence number.
    always_comb
    begin
        found_next   = s3_rec.search & s3_hole;
        retx_sn_next = found_next ? s3_rec.start_sn + sn_t'(s3_ones)
                                  : s3_rec.retransmit_sn;
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid;
        end
    end

    // Result word registers.
    always_ff @(posedge clk)
    begin
        if (s3_valid)
        begin
            out_rec_reg <= s3_rec;
            found_reg   <= found_next;
            retx_sn_reg <= retx_sn_next;
        end
    end

    assign done              = done_reg;
    assign send_allowed      = out_rec_reg.send_allowed;
    assign send_sn           = out_rec_reg.send_sn;
    assign next_sn_out       = out_rec_reg.next_sn;
    assign retransmit_sn_out = retx_sn_reg;
    assign do_retransmit_out = found_reg;
    assign recover_sn_out    = out_rec_reg.recover_sn;
    assign in_recovery_out   = out_rec_reg.in_recovery;

endmodule

`default_nettype wire

// ===== tb/sack_retransmit_select_unit_tb.sv =====
// Self-checking testbench for sack_retransmit_select_unit: directed and random sender records.
// Depends on srs_pkg and the unit; holds its own model of the transmit decision.
`timescale 1ns / 100ps

module sack_retransmit_select_unit_tb
    import srs_pkg::*;
();

    localparam int PIPE_LATENCY = 4;
    localparam int STALL_LIMIT  = 2000;

    // One sender record as driven on the command ports.
    typedef struct packed {
        logic             do_retx;
        sn_t              retx_sn;
        sn_t              acked_sn;
        logic             recovering;
        sn_t              rec_end_sn;
        sn_t              new_sn;
        logic             want_search;
        logic [BMP_W-1:0] sack;
    } qp_record_t;

    // One transmit decision as seen on the result ports.
    typedef struct packed {
        logic send_ok;
        sn_t  send_sn;
        sn_t  new_sn;
        sn_t  retx_sn;
        logic hole_found;
        sn_t  rec_end_sn;
        logic recovering;
    } tx_decision_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             do_retransmit = 1'b0;
    sn_t              retransmit_sn = '0;
    sn_t              last_acked_sn = '0;
    logic             in_recovery = 1'b0;
    sn_t              recover_sn = '0;
    sn_t              next_sn = '0;
    logic             find_hole = 1'b0;
    logic [BMP_W-1:0] sel_ack_bits = '0;
    logic             done;
    logic             send_allowed;
    sn_t              send_sn;
    sn_t              next_sn_out;
    sn_t              retransmit_sn_out;
    logic             do_retransmit_out;
    sn_t              recover_sn_out;
    logic             in_recovery_out;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    sn_t              cfg_data = '0;

    // Model copy of the in-flight limit and the decisions still owed by the unit.
    sn_t          in_flight_limit = MAX_IN_FLIGHT_RST;
    tx_decision_t pending_decisions[$];
    tx_decision_t oldest_decision;
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    logic         progress;

    sack_retransmit_select_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .do_retransmit     (do_retransmit),
        .retransmit_sn     (retransmit_sn),
        .last_acked_sn     (last_acked_sn),
        .in_recovery       (in_recovery),
        .recover_sn        (recover_sn),
        .next_sn           (next_sn),
        .find_hole         (find_hole),
        .sel_ack_bits      (sel_ack_bits),
        .done              (done),
        .send_allowed      (send_allowed),
        .send_sn           (send_sn),
        .next_sn_out       (next_sn_out),
        .retransmit_sn_out (retransmit_sn_out),
        .do_retransmit_out (do_retransmit_out),
        .recover_sn_out    (recover_sn_out),
        .in_recovery_out   (in_recovery_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // Computes the transmit decision for one record under the given in-flight limit.
    function automatic tx_decision_t predict_decision(qp_record_t r, sn_t limit);
        tx_decision_t     d;
        logic             search;
        sn_t              hole_base;
        logic [BMP_W-1:0] window;
        int unsigned      shift;
        int               ones;
        d            = '0;
        d.retx_sn    = r.retx_sn;
        d.new_sn     = r.new_sn;
        d.rec_end_sn = r.rec_end_sn;
        d.recovering = r.recovering;
        search       = r.want_search;
        if (r.do_retx && r.retx_sn >= r.acked_sn)
        begin
            // Pending retransmission is still inside the window: resend it.
            if (r.retx_sn == r.acked_sn)
                d.recovering = 1'b1;
            d.send_ok    = 1'b1;
            d.send_sn    = r.retx_sn;
            d.rec_end_sn = sn_t'(r.new_sn - sn_t'(1));
            search       = 1'b1;
        end
        else
        begin
            // A stale retransmission is dropped and cancels the search.
            if (r.do_retx)
                search = 1'b0;
            if (sn_t'(r.new_sn - r.acked_sn) < limit)
            begin
                d.send_ok = 1'b1;
                d.send_sn = r.new_sn;
                d.new_sn  = sn_t'(r.new_sn + sn_t'(1));
            end
        end
        if (search)
        begin
            // Align the window just past the retransmitted packet, or at the ack point.
            if (r.retx_sn >= r.acked_sn)
            begin
                shift     = {8'd0, r.retx_sn} - {8'd0, r.acked_sn} + 32'd1;
                window    = (shift >= WIN_BITS) ? '0 : ((r.sack & WIN_MASK) >> shift);
                hole_base = sn_t'(r.retx_sn + sn_t'(1));
            end
            else
            begin
                window    = r.sack & WIN_MASK;
                hole_base = r.acked_sn;
            end
            ones = 0;
            for (int k = 0; k < BMP_W; k++)
                if (window[k] && ones == k)
                    ones++;
            // A zero only counts as a hole when some packet beyond it was acked.
            if (ones < BMP_W && (window >> ones) != '0)
            begin
                d.retx_sn    = sn_t'(hole_base + sn_t'(ones));
                d.hole_found = 1'b1;
            end
        end
        return d;
    endfunction

    function automatic qp_record_t record_of(logic retx, sn_t rsn, sn_t acked, logic recov,
                                             sn_t rec_end, sn_t nsn, logic search,
                                             logic [BMP_W-1:0] sack);
        qp_record_t r;
        r.do_retx     = retx;
        r.retx_sn     = rsn;
        r.acked_sn    = acked;
        r.recovering  = recov;
        r.rec_end_sn  = rec_end;
        r.new_sn      = nsn;
        r.want_search = search;
        r.sack        = sack;
        return r;
    endfunction

    function automatic qp_record_t noise_record();
        return record_of(1'($urandom), sn_t'($urandom), sn_t'($urandom), 1'($urandom),
                         sn_t'($urandom), sn_t'($urandom), 1'($urandom),
                         BMP_W'({$urandom, $urandom}));
    endfunction

    // Mostly plausible records: sequence numbers near the ack point, structured bitmaps.
    function automatic qp_record_t plausible_record(sn_t limit);
        qp_record_t  r;
        int unsigned span_max;
        int unsigned gap_pos;
        r = noise_record();
        if ($urandom_range(0, 99) < 20)
            return r;
        if ($urandom_range(0, 9) == 0)
            r.acked_sn = sn_t'(24'hFFFFFF - $urandom_range(0, 40));
        span_max = (limit < sn_t'(120)) ? int'(limit) + 3 : 130;
        r.new_sn  = sn_t'(r.acked_sn + sn_t'($urandom_range(0, span_max)));
        r.do_retx = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 3))
            0: r.retx_sn = r.acked_sn;
            1: r.retx_sn = sn_t'(r.acked_sn - sn_t'($urandom_range(1, 3)));
            default: r.retx_sn = sn_t'(r.acked_sn + sn_t'($urandom_range(1, 70)));
        endcase
        case ($urandom_range(0, 5))
            0: r.sack = '1;
            1: r.sack = '0;
            default:
            begin
                // A run of acked packets, one hole, then random acks.
                gap_pos = $urandom_range(0, BMP_W - 1);
                r.sack  = {$urandom, $urandom} | ((64'd1 << gap_pos) - 64'd1);
                r.sack[gap_pos] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic apply_record(qp_record_t r);
        do_retransmit = r.do_retx;
        retransmit_sn = r.retx_sn;
        last_acked_sn = r.acked_sn;
        in_recovery   = r.recovering;
        recover_sn    = r.rec_end_sn;
        next_sn       = r.new_sn;
        find_hole     = r.want_search;
        sel_ack_bits  = r.sack;
    endtask

    // Presents one record and waits until the unit takes it; start stays high after.
    task automatic send_record(qp_record_t r);
        @(negedge clk);
        apply_record(r);
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(int cycles);
        for (int i = 0; i < cycles; i++)
        begin
            @(negedge clk);
            start = 1'b0;
            apply_record(noise_record());
        end
    endtask

    // Stops sending until every owed decision has come back, then lets the pipe settle.
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic set_in_flight_limit(sn_t limit);
        drain_results();
        cfg_data  = limit;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = sn_t'($urandom);
    endtask

    task automatic run_random_records(int count, bit with_gaps);
        for (int n = 0; n < count; n++)
        begin
            send_record(plausible_record(in_flight_limit));
            if (with_gaps && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 17));
        end
    endtask

    // Window edges, recovery entry, stale retransmissions and sequence wrap at the reset limit.
    task automatic test_directed_decisions();
        send_record(record_of(1, 24'd100, 24'd100, 0, 24'd5, 24'd120, 0, 64'hF1));
        send_record(record_of(1, 24'd200, 24'd100, 1, 24'd0, 24'd300, 0, '1));
        send_record(record_of(1, 24'd163, 24'd100, 0, 24'd0, 24'd170, 0, 64'h8000_0000_0000_0000));
        send_record(record_of(1, 24'd161, 24'd100, 0, 24'd0, 24'd170, 0, 64'h8000_0000_0000_0000));
        send_record(record_of(1, 24'd90, 24'd100, 0, 24'd7, 24'd110, 1, 64'h6));
        send_record(record_of(0, 24'd50, 24'd100, 0, 24'd0, 24'd110, 1, '1));
        send_record(record_of(0, 24'd50, 24'd100, 0, 24'd0, 24'd110, 1, '0));
        send_record(record_of(0, 24'd50, 24'd100, 0, 24'd0, 24'd110, 1, 64'h8000_0000_0000_0000));
        send_record(record_of(0, 24'd50, 24'd100, 0, 24'd0, 24'd110, 1, 64'hBFFF_FFFF_FFFF_FFFF));
        send_record(record_of(0, 24'd105, 24'd100, 1, 24'd3, 24'd110, 1, 64'hF3F));
        send_record(record_of(0, 24'd0, 24'd1000, 0, 24'd0, 24'd1063, 0, 64'h1234));
        send_record(record_of(0, 24'd0, 24'd1000, 0, 24'd0, 24'd1064, 0, 64'h1234));
        send_record(record_of(0, 24'd0, 24'hFFFFC0, 0, 24'd0, 24'hFFFFFF, 0, '0));
        send_record(record_of(0, 24'd0, 24'h000010, 0, 24'd0, 24'h00000F, 0, '0));
        send_record(record_of(1, 24'd5, 24'd5, 0, 24'h123456, 24'd0, 0, '0));
        send_record(record_of(1, 24'hFFFFFF, 24'hFFFFFF, 1, 24'd0, 24'd16, 0, 64'hA));
        send_record(record_of(1, 24'hFFFFFF, 24'd0, 1, 24'hFFFFFF, 24'hFFFFFF, 1, '1));
        send_record(record_of(0, 24'd0, 24'd0, 0, 24'd0, 24'd0, 0, '0));
    endtask

    // Limit of zero blocks new sends only; limit of one and the largest limit at their edges.
    task automatic test_limit_extremes();
        set_in_flight_limit(sn_t'(0));
        send_record(record_of(0, 24'd0, 24'd500, 0, 24'd0, 24'd500, 1, 64'h5));
        send_record(record_of(1, 24'd510, 24'd500, 0, 24'd0, 24'd520, 0, '1));
        run_random_records(30, 1);
        set_in_flight_limit(sn_t'(1));
        send_record(record_of(0, 24'd0, 24'd700, 0, 24'd0, 24'd700, 0, '0));
        send_record(record_of(0, 24'd0, 24'd700, 0, 24'd0, 24'd701, 0, '0));
        run_random_records(30, 1);
        set_in_flight_limit(sn_t'(24'hFFFFFF));
        send_record(record_of(0, 24'd0, 24'd10, 0, 24'd0, 24'd8, 0, '0));
        send_record(record_of(0, 24'd0, 24'd10, 0, 24'd0, 24'd9, 0, '0));
        run_random_records(60, 1);
    endtask

    // Random records with bursts of idle cycles under mid-range limits.
    task automatic test_gapped_traffic();
        set_in_flight_limit(sn_t'(16));
        run_random_records(80, 1);
        drain_results();
        run_random_records(80, 1);
        set_in_flight_limit(sn_t'($urandom_range(2, 200)));
        run_random_records(150, 1);
    endtask

    // Back-to-back records with no idle cycles at all.
    task automatic test_steady_stream();
        set_in_flight_limit(sn_t'(40));
        run_random_records(200, 0);
    endtask

    task automatic compare_field(string label, sn_t want, sn_t got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // Result check, limit tracking and stall watchdog, all sampled at the rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_flight_limit = MAX_IN_FLIGHT_RST;
            stall_cycles    = 0;
        end
        else
        begin
            progress = 1'b0;
            if (done)
            begin
                progress = 1'b1;
                if (pending_decisions.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: decision word with none expected, send_sn %h",
                             $time, send_sn);
                end
                else
                begin
                    oldest_decision = pending_decisions.pop_front();
                    compare_field("send_allowed", oldest_decision.send_ok, send_allowed);
                    compare_field("send_sn", oldest_decision.send_sn, send_sn);
                    compare_field("next_sn_out", oldest_decision.new_sn, next_sn_out);
                    compare_field("retransmit_sn_out", oldest_decision.retx_sn,
                                  retransmit_sn_out);
                    compare_field("do_retransmit_out", oldest_decision.hole_found,
                                  do_retransmit_out);
                    compare_field("recover_sn_out", oldest_decision.rec_end_sn, recover_sn_out);
                    compare_field("in_recovery_out", oldest_decision.recovering,
                                  in_recovery_out);
                end
            end
            if (start && !busy)
            begin
                progress = 1'b1;
                pending_decisions.push_back(predict_decision(
                    record_of(do_retransmit, retransmit_sn, last_acked_sn, in_recovery,
                              recover_sn, next_sn, find_hole, sel_ack_bits),
                    in_flight_limit));
            end
            if (cfg_valid && cfg_ready)
            begin
                progress        = 1'b1;
                in_flight_limit = cfg_data;
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        apply_record(record_of(0, '0, '0, 0, '0, '0, 0, '0));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_decisions();
        test_limit_extremes();
        test_gapped_traffic();
        test_steady_stream();

        @(negedge clk);
        start = 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
